// ===== hw/rtl/udv_pkg.sv =====
// ----------------------------------------------------------------------------
// udv_pkg
// Types and constants shared by the UTF-8 stream decoder and its checker.
// ----------------------------------------------------------------------------
package udv_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        scalar_ready;
    logic [20:0] code_point;
    logic        is_space;
    logic        is_ctrl;
    logic        byte_error;
    logic        string_done;
    logic        string_valid;
  } out_item_t;

  // Minimum-value classes for the overlong check
  localparam logic [1:0] ClsNone  = 2'd0;
  localparam logic [1:0] ClsTwo   = 2'd1;
  localparam logic [1:0] ClsThree = 2'd2;
  localparam logic [1:0] ClsFour  = 2'd3;

  localparam logic [7:0]  LeadTwoLo   = 8'hC2;
  localparam logic [7:0]  LeadTwoHi   = 8'hDF;
  localparam logic [7:0]  LeadThreeLo = 8'hE0;
  localparam logic [7:0]  LeadThreeHi = 8'hEF;
  localparam logic [7:0]  LeadFourLo  = 8'hF0;
  localparam logic [7:0]  LeadFourHi  = 8'hF4;

  localparam logic [20:0] MaxScalar = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;

  function automatic logic [20:0] min_scalar(input logic [1:0] cls);
    logic [20:0] m;
    case (cls)
      ClsTwo:   m = 21'h000080;
      ClsThree: m = 21'h000800;
      ClsFour:  m = 21'h010000;
      default:  m = 21'h000000;
    endcase
    return m;
  endfunction

  function automatic logic space_test(input logic [20:0] v);
    return (v >= 21'h09 && v <= 21'h0D) || v == 21'h20 || v == 21'h85 ||
           v == 21'hA0 || v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200A) ||
           v == 21'h2028 || v == 21'h2029 || v == 21'h202F || v == 21'h205F ||
           v == 21'h3000;
  endfunction

  function automatic logic ctrl_test(input logic [20:0] v);
    return v <= 21'h1F || (v >= 21'h7F && v <= 21'h9F);
  endfunction

endpackage

// ===== hw/rtl/udv_chan_if.sv =====
// ----------------------------------------------------------------------------
// udv_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface udv_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/utf8_stream_decode_validate.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate
// UTF-8 byte stream decoder and validator with per-string status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte of a string per item, with end_of_string set on
//   the last byte. out_ch returns exactly one item per input byte, in order:
//   a completed scalar with its space/control flags, the byte that first made
//   the string invalid, and on the last byte the overall validity.
//   Each result is registered and offered on out_ch from the result
//   register. One byte is accepted every cycle while in_ch.ready is high;
//   the decode step is a single level of compares and shifts between the
//   decode state registers and the result register.
//   A two-entry output (result register plus skid register) lets the block
//   take one more byte while a result waits; in_ch.ready drops only while
//   both entries are full, so a stalled receiver holds the input side after
//   one extra item.
//   Reset clears the decode state and empties the output, so the first byte
//   after reset starts a new string. The state also returns to its reset
//   values after each last byte.
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate
  import udv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  udv_chan_if.sink   in_ch,
  udv_chan_if.source out_ch
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;
  logic [1:0]  cls_q, cls_d;
  logic        sticky_q, sticky_d;

  out_item_t   res;
  out_item_t   out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        push, pop;

  logic [7:0]  b;
  logic        last;
  logic [20:0] cont_val;
  logic        err, done_ok;
  logic [20:0] cp;

  assign b    = in_ch.payload.in_byte;
  assign last = in_ch.payload.end_of_string;

  assign cont_val = {part_q[14:0], b[5:0]};

  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    cls_d    = cls_q;
    sticky_d = sticky_q;
    err      = 1'b0;
    done_ok  = 1'b0;
    cp       = '0;

    if (!sticky_q) begin
      if (pend_q == 2'd0) begin
        if (!b[7]) begin
          done_ok = 1'b1;
          cp      = {13'd0, b};
        end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
          pend_d = 2'd1;
          part_d = {16'd0, b[4:0]};
          cls_d  = ClsTwo;
        end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
          pend_d = 2'd2;
          part_d = {17'd0, b[3:0]};
          cls_d  = ClsThree;
        end else if (b >= LeadFourLo && b <= LeadFourHi) begin
          pend_d = 2'd3;
          part_d = {18'd0, b[2:0]};
          cls_d  = ClsFour;
        end else begin
          err = 1'b1;
        end
      end else if (b[7:6] == 2'b10) begin
        part_d = cont_val;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          // sequence complete: reject overlong, out-of-range and surrogates
          if (cont_val < min_scalar(cls_q) || cont_val > MaxScalar ||
              (cont_val >= SurrLo && cont_val <= SurrHi)) begin
            err = 1'b1;
          end else begin
            done_ok = 1'b1;
            cp      = cont_val;
          end
          part_d = '0;
          cls_d  = ClsNone;
        end
      end else begin
        err = 1'b1;
      end
      // truncated sequence at end of string
      if (!err && last && pend_d != 2'd0) begin
        err = 1'b1;
      end
      if (err) begin
        sticky_d = 1'b1;
      end
    end

    res              = '0;
    res.scalar_ready = done_ok;
    res.code_point   = cp;
    res.is_space     = done_ok & space_test(cp);
    res.is_ctrl      = done_ok & ctrl_test(cp);
    res.byte_error   = err;
    res.string_done  = last;
    res.string_valid = last & ~sticky_d;

    if (last) begin
      pend_d   = 2'd0;
      part_d   = '0;
      cls_d    = ClsNone;
      sticky_d = 1'b0;
    end
  end

  assign in_ch.ready = ~skid_valid_q;
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = out_valid_q & out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      part_q   <= '0;
      cls_q    <= ClsNone;
      sticky_q <= 1'b0;
    end else if (push) begin
      pend_q   <= pend_d;
      part_q   <= part_d;
      cls_q    <= cls_d;
      sticky_q <= sticky_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload side: advance skid into the result register, or load the new item
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

endmodule

// ===== hw/rtl/udv_checker.sv =====
// ----------------------------------------------------------------------------
// udv_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module udv_checker
  import udv_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_payload_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  a_scalar_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_payload_i.scalar_ready && out_payload_i.byte_error))
    else $error("scalar emitted on an error byte");

  a_valid_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.string_valid |->
      out_payload_i.string_done && !out_payload_i.byte_error)
    else $error("string reported valid off its last byte or with an error");

  a_flags_need_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.is_space || out_payload_i.is_ctrl) |->
      out_payload_i.scalar_ready)
    else $error("class flag without a scalar");

endmodule

bind utf8_stream_decode_validate udv_checker u_udv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_payload_i (out_ch.payload)
);
